@@ src/topological_sort_kahn_macros.svh @@
// assertion macros for the dependency sorter
// no dependencies; included by the top level
`ifndef TOPOLOGICAL_SORT_KAHN_MACROS_SVH
`define TOPOLOGICAL_SORT_KAHN_MACROS_SVH
`ifndef ASSERT_OFF
`define TSK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSK_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TSK_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSK_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ src/tsk_pkg.sv @@
// shared types and constants of the dependency sorter
// no dependencies; used by tsk_ctrl, tsk_datapath and topological_sort_kahn
package tsk_pkg;

	localparam int TSK_MAX_NODES = 32;
	localparam int TSK_MAX_EDGES = 128;
	localparam int NODE_W = 5;
	localparam int COUNT_W = 6;
	localparam int CMP_W = 7;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_SORT  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FOUND  = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_CYCLE      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RES_ADD   = 2'd0,
		RES_OK    = 2'd1,
		RES_CYCLE = 2'd2,
		RES_NODE  = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     add_edge;
		logic     clear_edges;
		logic     e_clr;
		logic     e_inc;
		logic     i_clr;
		logic     i_inc;
		logic     q_clr;
		logic     pop;
		logic     q_rd_i;
		logic     edge_rd;
		logic     deg_clr_wr;
		logic     deg_rd_node;
		logic     deg_rd_edge;
		logic     cnt_wr;
		logic     seed_chk;
		logic     walk_wr;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    n_zero;
		logic    edges_empty;
		logic    e_last;
		logic    i_last;
		logic    q_empty;
		logic    all_out;
		logic    out_free;
	} sts_t;

endpackage

@@ src/topological_sort_kahn.sv @@
// Add, clear, empty sort: the word is loaded in S_EXEC once the output is free; no new
// word is taken before that. A sort clears the in-degrees, counts them over the edges,
// seeds the queue and walks all edges per popped node; left-over nodes give a cycle word.
// Order words pass S_EMIT_RD, S_EMIT; the input is stalled until the last is loaded.
// Reset clears node count, edge count, counters and output valid; memories are not swept.
// Depends on tsk_pkg, tsk_ctrl, tsk_datapath and topological_sort_kahn_macros.svh
`include "topological_sort_kahn_macros.svh"
module topological_sort_kahn import tsk_pkg::*; #(
	parameter int MAX_NODES = TSK_MAX_NODES,
	parameter int MAX_EDGES = TSK_MAX_EDGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [NODE_W-1:0]  prerequisite_node,
	input  logic [NODE_W-1:0]  child_node,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [NODE_W-1:0]  node,
	output logic               has_node,
	output logic [1:0]         status,
	output logic               last
);

	cmd_t cmd;
	sts_t sts;

	tsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tsk_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.action            (action),
		.prerequisite_node (prerequisite_node),
		.child_node        (child_node),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.node              (node),
		.has_node          (has_node),
		.status            (status),
		.last              (last),
		.cmd               (cmd),
		.sts               (sts)
	);

	`TSK_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall, "no stall after accepted word")
	`TSK_ASSERT(a_order_word_ok, clk, arst_n, out_valid && has_node |-> status == ST_OK, "order word with bad status")
	`TSK_ASSERT_NEVER(a_single_status_word, clk, arst_n, out_valid && !has_node && !last, "status word not marked last")
	`TSK_ASSERT(a_busy_mid_order, clk, arst_n, out_valid && !last |-> in_stall, "input open while order is emitted")

endmodule

@@ src/tsk_ctrl.sv @@
// sequencer of the dependency sorter: accepts words, steps the sort phases
// depends on tsk_pkg
module tsk_ctrl import tsk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [15:0] {
		S_IDLE     = 16'b0000_0000_0000_0001,
		S_EXEC     = 16'b0000_0000_0000_0010,
		S_CLR      = 16'b0000_0000_0000_0100,
		S_CNT_RD   = 16'b0000_0000_0000_1000,
		S_CNT_DEG  = 16'b0000_0000_0001_0000,
		S_CNT_WR   = 16'b0000_0000_0010_0000,
		S_SEED_RD  = 16'b0000_0000_0100_0000,
		S_SEED_CHK = 16'b0000_0000_1000_0000,
		S_POP      = 16'b0000_0001_0000_0000,
		S_WALK_RD  = 16'b0000_0010_0000_0000,
		S_WALK_DEG = 16'b0000_0100_0000_0000,
		S_WALK_WR  = 16'b0000_1000_0000_0000,
		S_FIN      = 16'b0001_0000_0000_0000,
		S_EMIT_RD  = 16'b0010_0000_0000_0000,
		S_EMIT     = 16'b0100_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_next;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.action)
					ACT_ADD: begin
						if (sts.out_free) begin
							cmd.add_edge = 1'b1;
							cmd.out_load = 1'b1;
							cmd.res_sel = RES_ADD;
							state_next = S_IDLE;
						end
					end
					ACT_CLEAR: begin
						if (sts.out_free) begin
							cmd.clear_edges = 1'b1;
							cmd.out_load = 1'b1;
							cmd.res_sel = RES_OK;
							state_next = S_IDLE;
						end
					end
					ACT_SORT: begin
						if (sts.n_zero) begin
							if (sts.out_free) begin
								cmd.out_load = 1'b1;
								cmd.res_sel = RES_OK;
								state_next = S_IDLE;
							end
						end else begin
							cmd.i_clr = 1'b1;
							cmd.e_clr = 1'b1;
							cmd.q_clr = 1'b1;
							state_next = S_CLR;
						end
					end
					ACT_NOP: begin
						state_next = S_IDLE;
					end
				endcase
			end
			S_CLR: begin
				cmd.deg_clr_wr = 1'b1;
				if (sts.i_last) begin
					cmd.i_clr = 1'b1;
					state_next = sts.edges_empty ? S_SEED_RD : S_CNT_RD;
				end else begin
					cmd.i_inc = 1'b1;
				end
			end
			S_CNT_RD: begin
				cmd.edge_rd = 1'b1;
				state_next = S_CNT_DEG;
			end
			S_CNT_DEG: begin
				cmd.deg_rd_edge = 1'b1;
				state_next = S_CNT_WR;
			end
			S_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				if (sts.e_last) begin
					state_next = S_SEED_RD;
				end else begin
					cmd.e_inc = 1'b1;
					state_next = S_CNT_RD;
				end
			end
			S_SEED_RD: begin
				cmd.deg_rd_node = 1'b1;
				state_next = S_SEED_CHK;
			end
			S_SEED_CHK: begin
				cmd.seed_chk = 1'b1;
				if (sts.i_last) begin
					state_next = S_POP;
				end else begin
					cmd.i_inc = 1'b1;
					state_next = S_SEED_RD;
				end
			end
			S_POP: begin
				if (sts.q_empty) begin
					state_next = S_FIN;
				end else begin
					cmd.pop = 1'b1;
					cmd.e_clr = 1'b1;
					state_next = sts.edges_empty ? S_POP : S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				cmd.edge_rd = 1'b1;
				state_next = S_WALK_DEG;
			end
			S_WALK_DEG: begin
				cmd.deg_rd_edge = 1'b1;
				state_next = S_WALK_WR;
			end
			S_WALK_WR: begin
				cmd.walk_wr = 1'b1;
				if (sts.e_last) begin
					state_next = S_POP;
				end else begin
					cmd.e_inc = 1'b1;
					state_next = S_WALK_RD;
				end
			end
			S_FIN: begin
				if (sts.all_out) begin
					cmd.i_clr = 1'b1;
					state_next = S_EMIT_RD;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_sel = RES_CYCLE;
					state_next = S_IDLE;
				end
			end
			S_EMIT_RD: begin
				cmd.q_rd_i = 1'b1;
				state_next = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_sel = RES_NODE;
					if (sts.i_last) begin
						state_next = S_IDLE;
					end else begin
						cmd.i_inc = 1'b1;
						state_next = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

@@ src/tsk_datapath.sv @@
// datapath of the dependency sorter: edge store, in-degree and queue memories,
// counters and the output register; depends on tsk_pkg
module tsk_datapath import tsk_pkg::*; #(
	parameter int MAX_NODES = TSK_MAX_NODES,
	parameter int MAX_EDGES = TSK_MAX_EDGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	input  logic [1:0]         action,
	input  logic [NODE_W-1:0]  prerequisite_node,
	input  logic [NODE_W-1:0]  child_node,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [NODE_W-1:0]  node,
	output logic               has_node,
	output logic [1:0]         status,
	output logic               last,
	input  cmd_t               cmd,
	output sts_t               sts
);

	localparam int IDXW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int EAW = $clog2(MAX_EDGES);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int DEGW = EW;

	logic [COUNT_W-1:0] node_count_q;
	action_t            action_q;
	logic [NODE_W-1:0]  pre_q;
	logic [NODE_W-1:0]  dep_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      n_sel;
	logic [EW-1:0]      edges_q;
	logic [EW-1:0]      e_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      head_q;
	logic [CW-1:0]      tail_q;

	logic [NODE_W-1:0]  src_mem [MAX_EDGES];
	logic [NODE_W-1:0]  tgt_mem [MAX_EDGES];
	logic [NODE_W-1:0]  src_rd_q;
	logic [NODE_W-1:0]  tgt_rd_q;
	logic [DEGW-1:0]    deg_mem [MAX_NODES];
	logic [DEGW-1:0]    deg_rd_q;
	logic [IDXW-1:0]    q_mem [MAX_NODES];
	logic [IDXW-1:0]    q_rd_q;

	logic               out_valid_q;
	logic [NODE_W-1:0]  node_q;
	logic               has_node_q;
	status_t            status_q;
	logic               last_q;

	logic [CMP_W-1:0]   n_w;
	logic [CMP_W-1:0]   src_w;
	logic [CMP_W-1:0]   tgt_w;
	logic [CMP_W-1:0]   cur_w;
	logic [IDXW-1:0]    tgt_idx;
	logic [IDXW-1:0]    i_idx;
	logic               tgt_in;
	logic               edge_ok;
	logic               match;
	logic               walk_dec;
	logic               seed_push;
	logic               walk_push;
	logic               q_push;
	status_t            add_status;
	logic               add_ok;
	logic               out_free;
	logic               i_last;

	logic               deg_we;
	logic [IDXW-1:0]    deg_waddr;
	logic [DEGW-1:0]    deg_wdata;
	logic               deg_re;
	logic [IDXW-1:0]    deg_raddr;

	logic [NODE_W-1:0]  res_node;
	logic               res_has;
	status_t            res_status;
	logic               res_last;

	// nodes in use: the register clamped to the node capacity
	assign n_sel = (CMP_W'(node_count_q) > CMP_W'(MAX_NODES)) ? CW'(MAX_NODES)
		: CW'(node_count_q);

	assign n_w     = CMP_W'(n_q);
	assign src_w   = CMP_W'(src_rd_q);
	assign tgt_w   = CMP_W'(tgt_rd_q);
	assign cur_w   = CMP_W'(q_rd_q);
	assign tgt_idx = tgt_w[IDXW-1:0];
	assign i_idx   = i_q[IDXW-1:0];
	assign tgt_in  = (tgt_w < n_w);
	assign edge_ok = (src_w < n_w) && tgt_in;
	assign match   = (src_w == cur_w) && tgt_in;
	assign i_last  = (CW'(i_q + 1'b1) == n_q);

	assign walk_dec  = cmd.walk_wr && match && (deg_rd_q != '0);
	assign walk_push = walk_dec && (deg_rd_q == DEGW'(1)) && (tail_q < n_q);
	assign seed_push = cmd.seed_chk && (deg_rd_q == '0) && (tail_q < n_q);
	assign q_push    = seed_push || walk_push;

	always_comb begin
		if ((CMP_W'(pre_q) >= n_w) || (CMP_W'(dep_q) >= n_w)) begin
			add_status = ST_NOT_FOUND;
		end else if (edges_q >= EW'(MAX_EDGES)) begin
			add_status = ST_TABLE_FULL;
		end else begin
			add_status = ST_OK;
		end
	end
	assign add_ok = (add_status == ST_OK);

	assign out_free = !out_valid_q || !out_stall;

	assign sts.action      = action_q;
	assign sts.n_zero      = (n_q == '0);
	assign sts.edges_empty = (edges_q == '0);
	assign sts.e_last      = (EW'(e_q + 1'b1) == edges_q);
	assign sts.i_last      = i_last;
	assign sts.q_empty     = (head_q == tail_q);
	assign sts.all_out     = (tail_q == n_q);
	assign sts.out_free    = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action_t'(action);
			pre_q    <= prerequisite_node;
			dep_q    <= child_node;
			n_q      <= n_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q <= '0;
			e_q     <= '0;
			i_q     <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			if (cmd.clear_edges) begin
				edges_q <= '0;
			end else if (cmd.add_edge && add_ok) begin
				edges_q <= EW'(edges_q + 1'b1);
			end
			if (cmd.e_clr) begin
				e_q <= '0;
			end else if (cmd.e_inc) begin
				e_q <= EW'(e_q + 1'b1);
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= CW'(i_q + 1'b1);
			end
			if (cmd.q_clr) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.pop) begin
					head_q <= CW'(head_q + 1'b1);
				end
				if (q_push) begin
					tail_q <= CW'(tail_q + 1'b1);
				end
			end
		end
	end

	// edge store, kept in arrival order
	always_ff @(posedge clk) begin
		if (cmd.add_edge && add_ok) begin
			src_mem[edges_q[EAW-1:0]] <= pre_q;
			tgt_mem[edges_q[EAW-1:0]] <= dep_q;
		end
		if (cmd.edge_rd) begin
			src_rd_q <= src_mem[e_q[EAW-1:0]];
			tgt_rd_q <= tgt_mem[e_q[EAW-1:0]];
		end
	end

	// in-degree memory
	always_comb begin
		deg_we    = 1'b0;
		deg_waddr = i_idx;
		deg_wdata = '0;
		if (cmd.deg_clr_wr) begin
			deg_we = 1'b1;
		end else if (cmd.cnt_wr && edge_ok) begin
			deg_we    = 1'b1;
			deg_waddr = tgt_idx;
			deg_wdata = DEGW'(deg_rd_q + 1'b1);
		end else if (walk_dec) begin
			deg_we    = 1'b1;
			deg_waddr = tgt_idx;
			deg_wdata = DEGW'(deg_rd_q - 1'b1);
		end
	end

	assign deg_re    = cmd.deg_rd_node || (cmd.deg_rd_edge && tgt_in);
	assign deg_raddr = cmd.deg_rd_node ? i_idx : tgt_idx;

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		if (deg_re) begin
			deg_rd_q <= deg_mem[deg_raddr];
		end
	end

	// order queue; the popped entry stays in q_rd_q while its edges are walked
	always_ff @(posedge clk) begin
		if (q_push) begin
			q_mem[tail_q[IDXW-1:0]] <= seed_push ? i_idx : tgt_idx;
		end
		if (cmd.pop) begin
			q_rd_q <= q_mem[head_q[IDXW-1:0]];
		end else if (cmd.q_rd_i) begin
			q_rd_q <= q_mem[i_idx];
		end
	end

	always_comb begin
		res_node   = '0;
		res_has    = 1'b0;
		res_status = ST_OK;
		res_last   = 1'b1;
		unique case (cmd.res_sel)
			RES_ADD: begin
				res_status = add_status;
			end
			RES_OK: begin
				res_status = ST_OK;
			end
			RES_CYCLE: begin
				res_status = ST_CYCLE;
			end
			RES_NODE: begin
				res_node = cur_w[NODE_W-1:0];
				res_has  = 1'b1;
				res_last = i_last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			node_q     <= res_node;
			has_node_q <= res_has;
			status_q   <= res_status;
			last_q     <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign node      = node_q;
	assign has_node  = has_node_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule
